[rtl/sfm_pkg.sv]
// Shared types, register codes and a helper function for the substring first-match finder.
package sfm_pkg;

   // Width of the configuration bus and of its byte address.
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 6;

   // Register indexes, taken from csr address bits [5:3].
   typedef enum logic [2:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_LOW    = 3'd1,
      REG_PATTERN_HIGH   = 3'd2,
      REG_IGNORE_CASE    = 3'd3,
      REG_START_OFFSET   = 3'd4
   } sfm_reg_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [4:0]   pattern_length;
      logic [127:0] pattern_bytes;
      logic         ignore_case;
      logic [31:0]  start_offset;
   } sfm_cfg_type;

   // Outcome of one text, produced on its last word.
   typedef struct packed {
      logic        found;
      logic [31:0] index;
   } sfm_result_type;

   // Folds ASCII upper-case letters to lower case when case is ignored.
   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ignore_case);
      logic [7:0] r;
      r = c;
      if (ignore_case && (c >= 8'h41) && (c <= 8'h5A)) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

[rtl/sfm_csr.sv]
// Configuration register file with its bus port.
module sfm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sfm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sfm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sfm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output sfm_pkg::sfm_cfg_type              cfg
);
   import sfm_pkg::*;

   logic [4:0]  pattern_length_ff;
   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic        ignore_case_ff;
   logic [31:0] start_offset_ff;
   logic        write_en;
   sfm_reg_type reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = sfm_reg_type'(csr_paddr[5:3]);

   // Register writes; addresses past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= 5'd1;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         ignore_case_ff    <= 1'b1;
         start_offset_ff   <= '0;
      end else if (write_en) begin
         case (reg_index)
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_pwdata[4:0];
            REG_PATTERN_LOW:    pattern_low_ff    <= csr_pwdata;
            REG_PATTERN_HIGH:   pattern_high_ff   <= csr_pwdata;
            REG_IGNORE_CASE:    ignore_case_ff    <= csr_pwdata[0];
            REG_START_OFFSET:   start_offset_ff   <= csr_pwdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // Read data decoder.
   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LENGTH: csr_prdata = {59'd0, pattern_length_ff};
         REG_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         REG_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         REG_IGNORE_CASE:    csr_prdata = {63'd0, ignore_case_ff};
         REG_START_OFFSET:   csr_prdata = {32'd0, start_offset_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.pattern_length = pattern_length_ff;
   assign cfg.pattern_bytes  = {pattern_high_ff, pattern_low_ff};
   assign cfg.ignore_case    = ignore_case_ff;
   assign cfg.start_offset   = start_offset_ff;

endmodule

[rtl/sfm_window.sv]
// Sliding byte window, byte counter and parallel pattern compare.
module sfm_window #(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    word_valid,
   input  logic [7:0]              text_byte,
   input  logic                    end_of_text,
   input  sfm_pkg::sfm_cfg_type    cfg,
   output sfm_pkg::sfm_result_type result
);
   import sfm_pkg::*;

   localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]  window_ff [MAX_PATTERN];
   logic [7:0]  window_in [MAX_PATTERN];
   logic [31:0] count_ff;
   logic [31:0] count_in;
   logic        match_ff;
   logic        match_in;
   logic [31:0] index_ff;
   logic [31:0] index_in;
   logic [4:0]  len_m1;
   logic        count_full;
   logic        enough_bytes;
   logic [MAX_PATTERN-1:0] byte_ok;
   logic        hit_now;
   logic [31:0] index_now;

   // Pattern length minus one, clamped to the supported range.
   always_comb begin
      if (cfg.pattern_length == 5'd0) begin
         len_m1 = 5'd0;
      end else if (cfg.pattern_length > 5'(MAX_PATTERN)) begin
         len_m1 = 5'(MAX_PATTERN - 1);
      end else begin
         len_m1 = cfg.pattern_length - 5'd1;
      end
   end

   // Window after this word: slot 0 holds the newest byte.
   always_comb begin
      window_in[0] = text_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // Compare each pattern byte with its window slot; unused bytes always agree.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (5'(i) <= len_m1) begin
            byte_ok[i] = fold_byte(window_in[IDX_W'(len_m1 - 5'(i))], cfg.ignore_case) ==
                         fold_byte(cfg.pattern_bytes[8*i +: 8], cfg.ignore_case);
         end else begin
            byte_ok[i] = 1'b1;
         end
      end
   end

   // The counter holds bytes before this one, so it must reach length minus one.
   assign count_full   = (count_ff == 32'hFFFF_FFFF);
   assign enough_bytes = (count_ff >= 32'(len_m1));
   assign hit_now      = !match_ff && enough_bytes && (&byte_ok);
   assign index_now    = count_full ? (32'hFFFF_FFFF - 32'(len_m1) - 32'd1)
                                    : (count_ff - 32'(len_m1));

   // Next state; the last word of a text clears it for the next one.
   always_comb begin
      count_in = count_full ? count_ff : count_ff + 32'd1;
      match_in = match_ff || hit_now;
      index_in = hit_now ? index_now : index_ff;
      if (end_of_text) begin
         count_in = '0;
         match_in = 1'b0;
         index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         match_ff <= 1'b0;
         index_ff <= '0;
      end else if (word_valid) begin
         count_ff <= count_in;
         match_ff <= match_in;
         index_ff <= index_in;
      end
   end

   // Window contents are never read before they are written for a text.
   always_ff @(posedge clock) begin
      if (word_valid) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   assign result.found = match_ff || hit_now;
   assign result.index = match_ff ? index_ff : index_now;

endmodule

[rtl/substring_first_match_finder.sv]
// Top level of the substring first-match finder: config port, compare core, result register.
//
// Streams text one byte per word and reports, on the word marked tlast, whether the
// configured pattern (1 to MAX_PATTERN bytes, exact or ASCII case-insensitive) occurred
// and at which position (start_offset plus the byte index of the first match, 0 when not
// found). The window compare for a byte finishes in the cycle it is accepted, so a word
// can be accepted on every clock while the result register is not stalling. The only stall
// comes from the result register, which holds one result until rsp_tready takes it and
// lets the next word through in the same cycle it drains. Configure only while idle.
module substring_first_match_finder #(
   parameter int unsigned MAX_PATTERN = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // Text words.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] text_byte
   input  logic                           req_tlast,   // end_of_text
   // Result words.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // [31:0] match_position
   output logic                           rsp_tuser,   // [0] found
   // Configuration port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sfm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sfm_pkg::*;

   sfm_cfg_type    cfg;
   sfm_result_type result;
   logic           req_accept;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           found_ff;
   logic [31:0]    index_ff;

   sfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfm_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (req_accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .cfg         (cfg),
      .result      (result)
   );

   // Accept while the result register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded on the last word of a text.
   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         found_ff <= result.found;
         index_ff <= result.index;
      end
   end

   // User holds the start offset while a result waits (unenforced); position formed here.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = found_ff ? (cfg.start_offset + index_ff) : 32'd0;

endmodule
